### design/gradient_noise_2d_pixel_core_assert.svh
// Assertion macros for the gradient noise pixel core.
`ifndef GRADIENT_NOISE_2D_PIXEL_CORE_ASSERT_SVH
`define GRADIENT_NOISE_2D_PIXEL_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GN2D_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define GN2D_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gn2d_pkg.sv
// Shared types and constants of the gradient noise pixel core.
package gn2d_pkg;

  localparam int unsigned MAX_CELLS_DEF = 64;
  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CELL_W     = 7;
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned GRAD_W     = 16;
  localparam int unsigned NOISE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Queue between front and back; a power of two so pointers wrap freely.
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PIXEL,
    OP_DROP
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_CELLS  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e                      op;
    logic [PIX_W-1:0]         px;
    logic [PIX_W-1:0]         py;
    logic [IDX_W-1:0]         col;
    logic [IDX_W-1:0]         row;
    logic [2*GRAD_W-1:0]      gdata;
  } item_t;

  // Handshake between the queue head and the back pipeline.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

### design/gradient_noise_2d_pixel_core.sv
// Top level of the 2D gradient noise pixel generator.
//
// Generates 2D gradient noise one pixel per transaction. A transaction with
// mode 0 writes one Q1.14 gradient pair into the gradient table at
// (grad_col, grad_row) and returns nothing; loads outside the table are
// dropped. A transaction with mode 1 returns one noise byte for
// (pixel_x, pixel_y) together with those coordinates. Results leave in the
// order the pixels came in. The block sustains one transaction per clock
// while the output is not stalled: pixels and loads stream back to back. A
// transaction passes the cell-position divider, one quotient bit per stage,
// then the modulo-cells divider, then the table read, fade, blend and
// output stages. While a finished result waits under stall the whole
// pipeline holds, and a two-entry queue in front of it takes up to two more
// transactions before the input stalls. The table is not cleared at reset:
// write every entry a pixel can touch before computing pixels. Write
// configuration only while the block is idle.

`include "gradient_noise_2d_pixel_core_assert.svh"

module gradient_noise_2d_pixel_core import gn2d_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [PIX_W-1:0]         pixel_x_i,
  input  logic [PIX_W-1:0]         pixel_y_i,
  input  logic [IDX_W-1:0]         grad_col_i,
  input  logic [IDX_W-1:0]         grad_row_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [NOISE_W-1:0]       noise_value_o,
  output logic [PIX_W-1:0]         out_x_o,
  output logic [PIX_W-1:0]         out_y_o
);

  // Table and image bounds follow the package field widths.
  localparam int unsigned MaxCells = MAX_CELLS_DEF;
  localparam int unsigned MaxDim   = MAX_DIM_DEF;

  // Configuration registers, reset to a 256x256 image over 8 cells.
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [CELL_W-1:0] cells_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      cells_q  <= CELL_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_CELLS:  cells_q  <= cfg_data_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes so that zero never reaches a divider and the cell count
  // never exceeds the table.
  logic [DIM_W-1:0]  width_c;
  logic [DIM_W-1:0]  height_c;
  logic [CELL_W-1:0] cells_c;

  always_comb begin
    if (width_q == '0) begin
      width_c = DIM_W'(1);
    end else if (int'(width_q) > MaxDim) begin
      width_c = DIM_W'(MaxDim);
    end else begin
      width_c = width_q;
    end
    if (height_q == '0) begin
      height_c = DIM_W'(1);
    end else if (int'(height_q) > MaxDim) begin
      height_c = DIM_W'(MaxDim);
    end else begin
      height_c = height_q;
    end
    if (cells_q == '0) begin
      cells_c = CELL_W'(1);
    end else if (int'(cells_q) > MaxCells) begin
      cells_c = CELL_W'(MaxCells);
    end else begin
      cells_c = cells_q;
    end
  end

  head_t head;
  logic  pop;

  // Front: classify each transaction and queue it.
  gn2d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .grad_col_i (grad_col_i),
    .grad_row_i (grad_row_i),
    .grad_x_i   (grad_x_i),
    .grad_y_i   (grad_y_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: loads ride the pipeline and write the table at the read stage,
  // which keeps loads and pixel reads in transaction order.
  gn2d_back #(.FracBits(FracBits)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .width_i       (width_c),
    .height_i      (height_c),
    .cells_i       (cells_c),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o)
  );

  // The pipeline must freeze while a result is held.
  `GN2D_ASSERT_IMPL(a_no_pop_when_held, out_valid_o && out_stall_i, !pop, "pop while result held")
  // Never take from an empty queue.
  `GN2D_ASSERT_IMPL(a_pop_needs_head, pop, head.valid, "pop from empty queue")
  // The queue only fills on a transaction that is not drained the same cycle.
  `GN2D_ASSERT_NEXT(a_fill_needs_push, !in_stall_o && !in_valid_i, !in_stall_o, "queue filled without push")
  // A full queue always presents a valid head.
  `GN2D_ASSERT_IMPL(a_head_when_full, in_stall_o, head.valid, "full queue without head")

endmodule

### design/gn2d_front.sv
// Input side: accept, classify and queue transactions for the back pipeline.
module gn2d_front import gn2d_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [PIX_W-1:0]         pixel_x_i,
  input  logic [PIX_W-1:0]         pixel_y_i,
  input  logic [IDX_W-1:0]         grad_col_i,
  input  logic [IDX_W-1:0]         grad_row_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  output head_t                    head_o,
  input  logic                     pop_i
);

  localparam int unsigned MaxCells = MAX_CELLS_DEF;
  localparam int unsigned PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(Q_DEPTH + 1);

  op_e             cls;
  logic            accept;
  logic            push;
  item_t           entry;
  item_t           q_mem_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Loads aimed outside the table are dropped here.
  always_comb begin
    if (mode_i) begin
      cls = OP_PIXEL;
    end else if (int'(grad_col_i) < MaxCells && int'(grad_row_i) < MaxCells) begin
      cls = OP_LOAD;
    end else begin
      cls = OP_DROP;
    end
  end

  assign in_stall_o = (cnt_q == CntW'(Q_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (cls != OP_DROP);

  always_comb begin
    entry.op    = cls;
    entry.px    = pixel_x_i;
    entry.py    = pixel_y_i;
    entry.col   = grad_col_i;
    entry.row   = grad_row_i;
    entry.gdata = {grad_y_i, grad_x_i};
  end

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem_q[rd_ptr_q];

endmodule

### design/gn2d_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module gn2d_div #(
  parameter int unsigned NumW  = 35,
  parameter int unsigned DenW  = 13,
  parameter int unsigned TagW  = 8,
  parameter int unsigned Lanes = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [Lanes-1:0][NumW-1:0]          num_i,
  input  logic [Lanes-1:0][DenW-1:0]          den_i,
  input  logic [TagW-1:0]                     tag_i,
  output logic                                valid_o,
  output logic [Lanes-1:0][DenW+NumW-1:0]     res_o,
  output logic [TagW-1:0]                     tag_o
);

  logic [NumW:0]                  vld_s;
  logic [Lanes-1:0][NumW-1:0]     num_s [NumW+1];
  logic [Lanes-1:0][NumW-1:0]     quo_s [NumW+1];
  logic [Lanes-1:0][DenW-1:0]     rem_s [NumW+1];
  logic [Lanes-1:0][DenW-1:0]     den_s [NumW+1];
  logic [TagW-1:0]                tag_s [NumW+1];

  assign vld_s[0] = valid_i;
  assign num_s[0] = num_i;
  assign quo_s[0] = '0;
  assign rem_s[0] = '0;
  assign den_s[0] = den_i;
  assign tag_s[0] = tag_i;

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic                         vld_q;
    logic [Lanes-1:0][NumW-1:0]   num_d, num_q;
    logic [Lanes-1:0][NumW-1:0]   quo_d, quo_q;
    logic [Lanes-1:0][DenW-1:0]   rem_d, rem_q;
    logic [Lanes-1:0][DenW-1:0]   den_q;
    logic [TagW-1:0]              tag_q;

    always_comb begin
      logic [DenW:0] trial;
      logic [DenW:0] diff;
      logic          ge;
      for (int l = 0; l < Lanes; l++) begin
        trial    = {rem_s[k][l], num_s[k][l][NumW-1]};
        diff     = trial - {1'b0, den_s[k][l]};
        ge       = (trial >= {1'b0, den_s[k][l]});
        rem_d[l] = ge ? diff[DenW-1:0] : trial[DenW-1:0];
        quo_d[l] = NumW'({quo_s[k][l], ge});
        num_d[l] = num_s[k][l] << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q <= num_d;
        quo_q <= quo_d;
        rem_q <= rem_d;
        den_q <= den_s[k];
        tag_q <= tag_s[k];
      end
    end

    assign vld_s[k+1] = vld_q;
    assign num_s[k+1] = num_q;
    assign quo_s[k+1] = quo_q;
    assign rem_s[k+1] = rem_q;
    assign den_s[k+1] = den_q;
    assign tag_s[k+1] = tag_q;
  end

  assign valid_o = vld_s[NumW];
  assign tag_o   = tag_s[NumW];

  for (genvar l = 0; l < Lanes; l++) begin : g_res
    assign res_o[l] = {rem_s[NumW][l], quo_s[NumW][l]};
  end

endmodule

### design/gn2d_back.sv
// Back pipeline: cell split, gradient table, fade, interpolation and output byte.
module gn2d_back import gn2d_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  head_t              head_i,
  output logic               pop_o,
  input  logic [DIM_W-1:0]   width_i,
  input  logic [DIM_W-1:0]   height_i,
  input  logic [CELL_W-1:0]  cells_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [NOISE_W-1:0] noise_value_o,
  output logic [PIX_W-1:0]   out_x_o,
  output logic [PIX_W-1:0]   out_y_o
);

  localparam int unsigned MaxCells = MAX_CELLS_DEF;
  localparam int unsigned F     = FracBits;
  localparam int unsigned PW    = PIX_W + CELL_W;
  localparam int unsigned NW1   = PW + F;
  localparam int unsigned Depth = MaxCells * MaxCells;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned Tag2W = ItemW + 2 * F;
  localparam int unsigned PrW   = F + 18;
  localparam int unsigned LW    = F + 5;

  localparam logic signed [F+4:0]  K15   = (F+5)'(15) << F;
  localparam logic signed [F+4:0]  K10   = (F+5)'(10) << F;
  localparam logic signed [F+1:0]  OneS  = (F+2)'(1) << F;
  localparam logic signed [17:0]   SqrtS = 18'sd46341;
  localparam logic signed [F+23:0] HalfS = (F+24)'(1) << (F + 15);
  localparam logic signed [F+23:0] LimS  = (F+24)'(1) << (F + 16);
  localparam logic [F+16:0]        Lim   = (F+17)'(1) << (F + 16);

  function automatic logic [AW-1:0] tab_addr(logic [CELL_W-1:0] c, logic [CELL_W-1:0] r);
    return AW'(int'(c) * MaxCells + int'(r));
  endfunction

  logic en;
  logic out_valid_q;

  // Advance the whole pipeline unless a finished result is held.
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = head_i.valid && en;

  // ---- divide: p*cells*2^F / size, both axes ----
  logic [1:0][NW1-1:0]          d1_num;
  logic [1:0][DIM_W-1:0]        d1_den;
  logic                         d1_v;
  logic [1:0][DIM_W+NW1-1:0]    d1_res;
  logic [ItemW-1:0]             d1_tag;

  assign d1_num[0] = {PW'(head_i.item.px) * PW'(cells_i), F'(0)};
  assign d1_num[1] = {PW'(head_i.item.py) * PW'(cells_i), F'(0)};
  assign d1_den[0] = width_i;
  assign d1_den[1] = height_i;

  gn2d_div #(.NumW(NW1), .DenW(DIM_W), .TagW(ItemW), .Lanes(2)) u_div_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (head_i.valid),
    .num_i   (d1_num),
    .den_i   (d1_den),
    .tag_i   (head_i.item),
    .valid_o (d1_v),
    .res_o   (d1_res),
    .tag_o   (d1_tag)
  );

  // ---- cell index modulo cells ----
  logic [1:0][PW-1:0]           d2_num;
  logic [1:0][CELL_W-1:0]       d2_den;
  logic                         d2_v;
  logic [1:0][CELL_W+PW-1:0]    d2_res;
  logic [Tag2W-1:0]             d2_tag;

  assign d2_num[0] = d1_res[0][NW1-1:F];
  assign d2_num[1] = d1_res[1][NW1-1:F];
  assign d2_den[0] = cells_i;
  assign d2_den[1] = cells_i;

  gn2d_div #(.NumW(PW), .DenW(CELL_W), .TagW(Tag2W), .Lanes(2)) u_div_cell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_v),
    .num_i   (d2_num),
    .den_i   (d2_den),
    .tag_i   ({d1_tag, d1_res[0][F-1:0], d1_res[1][F-1:0]}),
    .valid_o (d2_v),
    .res_o   (d2_res),
    .tag_o   (d2_tag)
  );

  // ---- P1: corner addresses, fade step one ----
  item_t                 d2_item;
  logic [F-1:0]          d2_fx, d2_fy;
  logic [CELL_W-1:0]     cx0, cy0, cx1, cy1;
  logic [CELL_W:0]       incx, incy;
  logic signed [F+4:0]   tsx, tsy;
  logic [2*F-1:0]        sqx, sqy;

  logic                  p1_v_q;
  item_t                 p1_item_q;
  logic [F-1:0]          p1_fx_q, p1_fy_q, p1_t2x_q, p1_t2y_q;
  logic signed [F+4:0]   p1_ax_q, p1_ay_q;
  logic [AW-1:0]         p1_a00_q, p1_a10_q, p1_a01_q, p1_a11_q, p1_wa_q;

  always_comb begin
    d2_item = item_t'(d2_tag[Tag2W-1:2*F]);
    d2_fx   = d2_tag[2*F-1:F];
    d2_fy   = d2_tag[F-1:0];
    cx0     = d2_res[0][CELL_W+PW-1:PW];
    cy0     = d2_res[1][CELL_W+PW-1:PW];
    incx    = {1'b0, cx0} + 1'b1;
    incy    = {1'b0, cy0} + 1'b1;
    cx1     = (incx == {1'b0, cells_i}) ? '0 : incx[CELL_W-1:0];
    cy1     = (incy == {1'b0, cells_i}) ? '0 : incy[CELL_W-1:0];
    tsx     = $signed({5'b0, d2_fx});
    tsy     = $signed({5'b0, d2_fy});
    sqx     = (2*F)'(d2_fx) * (2*F)'(d2_fx);
    sqy     = (2*F)'(d2_fy) * (2*F)'(d2_fy);
  end

  // ---- P2: table read, fade step two ----
  logic [2*GRAD_W-1:0]   tab_a_q [Depth];
  logic [2*GRAD_W-1:0]   tab_b_q [Depth];
  logic [2*GRAD_W-1:0]   p2_g00_q, p2_g10_q, p2_g01_q, p2_g11_q;
  logic                  p2_v_q;
  item_t                 p2_item_q;
  logic [F-1:0]          p2_fx_q, p2_fy_q, p2_t3x_q, p2_t3y_q;
  logic signed [F+4:0]   p2_bx_q, p2_by_q;
  logic signed [2*F+5:0] atx, aty;
  logic [2*F-1:0]        cubx, cuby;

  always_comb begin
    atx  = p1_ax_q * $signed({1'b0, p1_fx_q});
    aty  = p1_ay_q * $signed({1'b0, p1_fy_q});
    cubx = (2*F)'(p1_t2x_q) * (2*F)'(p1_fx_q);
    cuby = (2*F)'(p1_t2y_q) * (2*F)'(p1_fy_q);
  end

  // Two copies of the table give four reads a cycle; loads write both.
  always_ff @(posedge clk_i) begin
    if (en && p1_v_q && p1_item_q.op == OP_LOAD) begin
      tab_a_q[p1_wa_q] <= p1_item_q.gdata;
      tab_b_q[p1_wa_q] <= p1_item_q.gdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_g00_q <= tab_a_q[p1_a00_q];
      p2_g10_q <= tab_a_q[p1_a10_q];
      p2_g01_q <= tab_b_q[p1_a01_q];
      p2_g11_q <= tab_b_q[p1_a11_q];
    end
  end

  // ---- P3: corner products, fade step three ----
  logic signed [F+1:0]   ox0, ox1, oy0, oy1;
  logic signed [2*F+5:0] tbx, tby;
  logic                  p3_v_q;
  item_t                 p3_item_q;
  logic signed [PrW-1:0] p3_x00_q, p3_y00_q, p3_x10_q, p3_y10_q;
  logic signed [PrW-1:0] p3_x01_q, p3_y01_q, p3_x11_q, p3_y11_q;
  logic signed [F+1:0]   p3_sx_q, p3_sy_q;

  always_comb begin
    ox0 = $signed({2'b0, p2_fx_q});
    oy0 = $signed({2'b0, p2_fy_q});
    ox1 = ox0 - OneS;
    oy1 = oy0 - OneS;
    tbx = $signed({1'b0, p2_t3x_q}) * p2_bx_q;
    tby = $signed({1'b0, p2_t3y_q}) * p2_by_q;
  end

  // ---- P4: dot products ----
  logic signed [PrW:0]   s00, s10, s01, s11;
  logic                  p4_v_q;
  item_t                 p4_item_q;
  logic signed [LW-1:0]  p4_c00_q, p4_c10_q, p4_c01_q, p4_c11_q;
  logic signed [F+1:0]   p4_sx_q, p4_sy_q;

  always_comb begin
    s00 = p3_x00_q + p3_y00_q;
    s10 = p3_x10_q + p3_y10_q;
    s01 = p3_x01_q + p3_y01_q;
    s11 = p3_x11_q + p3_y11_q;
  end

  // ---- P5..P8: bilinear blend ----
  logic signed [F+5:0]   dlx, dhx;
  logic                  p5_v_q;
  item_t                 p5_item_q;
  logic signed [2*F+7:0] p5_dlo_q, p5_dhi_q;
  logic signed [LW-1:0]  p5_c00_q, p5_c01_q;
  logic signed [F+1:0]   p5_sy_q;

  logic                  p6_v_q;
  item_t                 p6_item_q;
  logic signed [LW-1:0]  p6_lo_q, p6_hi_q;
  logic signed [F+1:0]   p6_sy_q;

  logic                  p7_v_q;
  item_t                 p7_item_q;
  logic signed [2*F+7:0] p7_dv_q;
  logic signed [LW-1:0]  p7_lo_q;

  logic                  p8_v_q;
  item_t                 p8_item_q;
  logic signed [LW-1:0]  p8_v_val_q;

  always_comb begin
    dlx = p4_c10_q - p4_c00_q;
    dhx = p4_c11_q - p4_c01_q;
  end

  // ---- P9: scale, bias and clamp ----
  logic signed [F+23:0]  nsum;
  logic [F+16:0]         n_d;
  logic                  p9_v_q;
  item_t                 p9_item_q;
  logic [F+16:0]         p9_n_q;
  logic [F+24:0]         n255;

  always_comb begin
    nsum = p8_v_val_q * SqrtS + HalfS;
    if (nsum < 0) begin
      n_d = '0;
    end else if (nsum > LimS) begin
      n_d = Lim;
    end else begin
      n_d = nsum[F+16:0];
    end
    n255 = ((F+25)'(p9_n_q) << 8) - (F+25)'(p9_n_q);
  end

  logic [NOISE_W-1:0]    noise_q;
  logic [PIX_W-1:0]      ox_q, oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      p4_v_q      <= 1'b0;
      p5_v_q      <= 1'b0;
      p6_v_q      <= 1'b0;
      p7_v_q      <= 1'b0;
      p8_v_q      <= 1'b0;
      p9_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      p1_v_q      <= d2_v;
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      p4_v_q      <= p3_v_q;
      p5_v_q      <= p4_v_q;
      p6_v_q      <= p5_v_q;
      p7_v_q      <= p6_v_q;
      p8_v_q      <= p7_v_q;
      p9_v_q      <= p8_v_q;
      out_valid_q <= p9_v_q && (p9_item_q.op == OP_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_item_q <= d2_item;
      p1_fx_q   <= d2_fx;
      p1_fy_q   <= d2_fy;
      p1_ax_q   <= (tsx <<< 2) + (tsx <<< 1) - K15;
      p1_ay_q   <= (tsy <<< 2) + (tsy <<< 1) - K15;
      p1_t2x_q  <= sqx[2*F-1:F];
      p1_t2y_q  <= sqy[2*F-1:F];
      p1_a00_q  <= tab_addr(cx0, cy0);
      p1_a10_q  <= tab_addr(cx1, cy0);
      p1_a01_q  <= tab_addr(cx0, cy1);
      p1_a11_q  <= tab_addr(cx1, cy1);
      p1_wa_q   <= tab_addr(CELL_W'(d2_item.col), CELL_W'(d2_item.row));

      p2_item_q <= p1_item_q;
      p2_fx_q   <= p1_fx_q;
      p2_fy_q   <= p1_fy_q;
      p2_bx_q   <= (F+5)'(atx >>> F) + K10;
      p2_by_q   <= (F+5)'(aty >>> F) + K10;
      p2_t3x_q  <= cubx[2*F-1:F];
      p2_t3y_q  <= cuby[2*F-1:F];

      p3_item_q <= p2_item_q;
      p3_x00_q  <= $signed(p2_g00_q[GRAD_W-1:0]) * ox0;
      p3_y00_q  <= $signed(p2_g00_q[2*GRAD_W-1:GRAD_W]) * oy0;
      p3_x10_q  <= $signed(p2_g10_q[GRAD_W-1:0]) * ox1;
      p3_y10_q  <= $signed(p2_g10_q[2*GRAD_W-1:GRAD_W]) * oy0;
      p3_x01_q  <= $signed(p2_g01_q[GRAD_W-1:0]) * ox0;
      p3_y01_q  <= $signed(p2_g01_q[2*GRAD_W-1:GRAD_W]) * oy1;
      p3_x11_q  <= $signed(p2_g11_q[GRAD_W-1:0]) * ox1;
      p3_y11_q  <= $signed(p2_g11_q[2*GRAD_W-1:GRAD_W]) * oy1;
      p3_sx_q   <= (F+2)'(tbx >>> F);
      p3_sy_q   <= (F+2)'(tby >>> F);

      p4_item_q <= p3_item_q;
      p4_c00_q  <= LW'(s00 >>> 14);
      p4_c10_q  <= LW'(s10 >>> 14);
      p4_c01_q  <= LW'(s01 >>> 14);
      p4_c11_q  <= LW'(s11 >>> 14);
      p4_sx_q   <= p3_sx_q;
      p4_sy_q   <= p3_sy_q;

      p5_item_q <= p4_item_q;
      p5_dlo_q  <= dlx * p4_sx_q;
      p5_dhi_q  <= dhx * p4_sx_q;
      p5_c00_q  <= p4_c00_q;
      p5_c01_q  <= p4_c01_q;
      p5_sy_q   <= p4_sy_q;

      p6_item_q <= p5_item_q;
      p6_lo_q   <= p5_c00_q + LW'(p5_dlo_q >>> F);
      p6_hi_q   <= p5_c01_q + LW'(p5_dhi_q >>> F);
      p6_sy_q   <= p5_sy_q;

      p7_item_q <= p6_item_q;
      p7_dv_q   <= (p6_hi_q - p6_lo_q) * p6_sy_q;
      p7_lo_q   <= p6_lo_q;

      p8_item_q  <= p7_item_q;
      p8_v_val_q <= p7_lo_q + LW'(p7_dv_q >>> F);

      p9_item_q <= p8_item_q;
      p9_n_q    <= n_d;

      noise_q   <= n255[F+23:F+16];
      ox_q      <= p9_item_q.px;
      oy_q      <= p9_item_q.py;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;
  assign out_x_o       = ox_q;
  assign out_y_o       = oy_q;

endmodule
